/* src/iee_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types and constants of the integer expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

  localparam int WORD_WIDTH  = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(WORD_WIDTH);

  // mode codes of an input word
  localparam logic [1:0] MODE_SYMBOL = 2'd0;
  localparam logic [1:0] MODE_EVAL   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // key codes
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_MUL   = 8'h2a;
  localparam logic [7:0] CH_DIV   = 8'h2f;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  typedef enum logic [1:0] {
    PH_OPERAND,
    PH_NUMBER,
    PH_STOPPED
  } phase_t;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_MUL,
    PEND_DIV
  } pend_t;

  typedef enum logic {
    MD_OP_MUL,
    MD_OP_DIV
  } md_op_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_RUN,
    MD_FIX
  } md_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FACTOR,
    ST_WAIT,
    ST_POST,
    ST_TERM,
    ST_RESULT
  } st_t;

  typedef struct packed {
    logic   start;
    md_op_t op;
  } md_req_t;

endpackage

/* src/iee_muldiv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_muldiv
// Bit-serial multiply (wrapping) and signed divide (truncating), one bit a cycle.
// ----------------------------------------------------------------------------
module iee_muldiv (
  input  logic                              clk,
  input  logic                              rst,
  input  iee_pkg::md_req_t                  req,
  input  logic [iee_pkg::WORD_WIDTH-1:0]    a,
  input  logic [iee_pkg::WORD_WIDTH-1:0]    b,
  output logic                              done,
  output logic [iee_pkg::WORD_WIDTH-1:0]    result
);

  localparam int W = iee_pkg::WORD_WIDTH;

  iee_pkg::md_state_t state;
  iee_pkg::md_state_t state_next;
  iee_pkg::md_op_t    op;
  logic [W-1:0]       acc;
  logic [W-1:0]       x;
  logic [W-1:0]       y;
  logic               neg;
  logic [iee_pkg::CNT_W-1:0] cnt;

  logic [W:0]         rem_shift;
  logic [W:0]         diff;
  logic               last_iter;

  assign rem_shift = {acc, x[W-1]};
  assign diff      = rem_shift - {1'b0, y};
  assign last_iter = (cnt == iee_pkg::CNT_W'(W - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      iee_pkg::MD_IDLE: if (req.start) state_next = iee_pkg::MD_RUN;
      iee_pkg::MD_RUN:  if (last_iter) state_next = iee_pkg::MD_FIX;
      iee_pkg::MD_FIX:  state_next = iee_pkg::MD_IDLE;
      default:          state_next = iee_pkg::MD_IDLE;
    endcase
  end

  always_comb begin
    done   = (state == iee_pkg::MD_FIX);
    result = acc;
    if (op == iee_pkg::MD_OP_DIV) begin
      result = neg ? (W'(0) - x) : x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iee_pkg::MD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      iee_pkg::MD_IDLE: begin
        if (req.start) begin
          op  <= req.op;
          acc <= '0;
          cnt <= '0;
          if (req.op == iee_pkg::MD_OP_DIV) begin
            // divide on magnitudes, fix the sign at the end
            x   <= a[W-1] ? (W'(0) - a) : a;
            y   <= b[W-1] ? (W'(0) - b) : b;
            neg <= a[W-1] ^ b[W-1];
          end else begin
            x   <= a;
            y   <= b;
            neg <= 1'b0;
          end
        end
      end
      iee_pkg::MD_RUN: begin
        cnt <= cnt + 1'b1;
        if (op == iee_pkg::MD_OP_MUL) begin
          if (y[0]) acc <= acc + x;
          x <= {x[W-2:0], 1'b0};
          y <= {1'b0, y[W-1:1]};
        end else begin
          // restoring step, quotient bits shift into x
          if (!diff[W]) begin
            acc <= diff[W-1:0];
            x   <= {x[W-2:0], 1'b1};
          end else begin
            acc <= rem_shift[W-1:0];
            x   <= {x[W-2:0], 1'b0};
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/integer_expression_evaluator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_expression_evaluator
// Calculator key parser with + - * / precedence over wrapping integers.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one key word: mode (0 key, 1 evaluate, 2 clear) and the ASCII
//   key code. Every accepted word gives exactly one result word on m_*:
//   value, error and done_res; value and error are zero unless done_res is 1.
//   A pending * or / runs through one shared shift-add / restoring-divide unit
//   at one bit a cycle; words that close no pending * or / do not use it. The
//   block takes one word at a time: s_tready is high only while no word is in
//   work, and the next word can be taken in the cycle after a result is
//   registered.
//   Results sit in an output register; a new word may be accepted while it
//   waits. If the receiver stalls, the next result holds in the sequencer
//   until the register frees, and s_tready stays low meanwhile.
//   Reset (rst, synchronous) clears all accumulators and the error flag; an
//   evaluate right after reset or clear reports value 0, error 0. The key
//   following an evaluate starts a new expression.
// ----------------------------------------------------------------------------
module integer_expression_evaluator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // mode[1:0], symbol[9:2], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // value[31:0], error[32], done_res[33], zero pad
);

  localparam int W = iee_pkg::WORD_WIDTH;

  iee_pkg::st_t      state;
  iee_pkg::st_t      state_next;

  logic [1:0]        mode_q;
  logic [7:0]        sym_q;

  logic [W-1:0]      sum_acc;
  logic [W-1:0]      term_acc;
  logic [W-1:0]      number_acc;
  logic              add_is_sub;
  iee_pkg::pend_t    mul_pending;
  logic              negate_parity;
  iee_pkg::phase_t   phase;
  logic              error_seen;
  logic              fresh_start;

  logic              out_valid;
  logic [39:0]       out_data;

  logic              is_digit;
  logic              is_mul;
  logic              is_div;
  logic              is_plus;
  logic              is_minus;
  logic              is_eval;
  logic [W-1:0]      factor_val;
  logic              out_free;

  iee_pkg::md_req_t  md_req;
  logic              md_done;
  logic [W-1:0]      md_result;

  logic signed [iee_pkg::VALUE_WIDTH-1:0] value_ext;

  assign is_digit   = (sym_q >= iee_pkg::CH_0) && (sym_q <= iee_pkg::CH_9);
  assign is_mul     = (sym_q == iee_pkg::CH_MUL);
  assign is_div     = (sym_q == iee_pkg::CH_DIV);
  assign is_plus    = (sym_q == iee_pkg::CH_PLUS);
  assign is_minus   = (sym_q == iee_pkg::CH_MINUS);
  assign is_eval    = (mode_q == iee_pkg::MODE_EVAL);
  assign factor_val = negate_parity ? (W'(0) - number_acc) : number_acc;
  assign out_free   = !out_valid || m_tready;
  assign value_ext  = iee_pkg::VALUE_WIDTH'($signed(sum_acc));

  iee_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .req    (md_req),
    .a      (term_acc),
    .b      (factor_val),
    .done   (md_done),
    .result (md_result)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      iee_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = iee_pkg::ST_DISPATCH;
      end
      iee_pkg::ST_DISPATCH: begin
        unique case (mode_q)
          iee_pkg::MODE_SYMBOL: begin
            if (fresh_start) begin
              state_next = iee_pkg::ST_DISPATCH;
            end else if (phase == iee_pkg::PH_OPERAND) begin
              state_next = (is_digit || is_minus) ? iee_pkg::ST_RESULT
                                                  : iee_pkg::ST_FACTOR;
            end else if (phase == iee_pkg::PH_NUMBER) begin
              state_next = is_digit ? iee_pkg::ST_RESULT : iee_pkg::ST_FACTOR;
            end else begin
              state_next = iee_pkg::ST_RESULT;
            end
          end
          iee_pkg::MODE_EVAL: begin
            if (fresh_start || phase == iee_pkg::PH_STOPPED) begin
              state_next = iee_pkg::ST_RESULT;
            end else begin
              state_next = iee_pkg::ST_FACTOR;
            end
          end
          default: state_next = iee_pkg::ST_RESULT;
        endcase
      end
      iee_pkg::ST_FACTOR: begin
        if ((mul_pending == iee_pkg::PEND_MUL) ||
            (mul_pending == iee_pkg::PEND_DIV && factor_val != '0)) begin
          state_next = iee_pkg::ST_WAIT;
        end else begin
          state_next = iee_pkg::ST_POST;
        end
      end
      iee_pkg::ST_WAIT: begin
        if (md_done) state_next = iee_pkg::ST_POST;
      end
      iee_pkg::ST_POST: begin
        if (!is_eval && (is_mul || is_div)) begin
          state_next = iee_pkg::ST_RESULT;
        end else begin
          state_next = iee_pkg::ST_TERM;
        end
      end
      iee_pkg::ST_TERM: state_next = iee_pkg::ST_RESULT;
      iee_pkg::ST_RESULT: begin
        if (out_free) state_next = iee_pkg::ST_IDLE;
      end
      default: state_next = iee_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready     = (state == iee_pkg::ST_IDLE);
    m_tvalid     = out_valid;
    m_tdata      = out_data;
    md_req.start = 1'b0;
    md_req.op    = (mul_pending == iee_pkg::PEND_DIV) ? iee_pkg::MD_OP_DIV
                                                      : iee_pkg::MD_OP_MUL;
    if (state == iee_pkg::ST_FACTOR) begin
      md_req.start = (mul_pending == iee_pkg::PEND_MUL) ||
                     (mul_pending == iee_pkg::PEND_DIV && factor_val != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iee_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == iee_pkg::ST_IDLE && s_tvalid) begin
      mode_q <= s_tdata[1:0];
      sym_q  <= s_tdata[9:2];
    end
  end

  // expression state
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc       <= '0;
      term_acc      <= '0;
      number_acc    <= '0;
      add_is_sub    <= 1'b0;
      mul_pending   <= iee_pkg::PEND_NONE;
      negate_parity <= 1'b0;
      phase         <= iee_pkg::PH_OPERAND;
      error_seen    <= 1'b0;
      fresh_start   <= 1'b1;
    end else begin
      unique case (state)
        iee_pkg::ST_DISPATCH: begin
          unique case (mode_q)
            iee_pkg::MODE_SYMBOL: begin
              if (fresh_start) begin
                // first key of a new expression: wipe, then parse next cycle
                sum_acc       <= '0;
                term_acc      <= '0;
                number_acc    <= '0;
                add_is_sub    <= 1'b0;
                mul_pending   <= iee_pkg::PEND_NONE;
                negate_parity <= 1'b0;
                phase         <= iee_pkg::PH_OPERAND;
                error_seen    <= 1'b0;
                fresh_start   <= 1'b0;
              end else if (phase == iee_pkg::PH_OPERAND) begin
                if (is_digit) begin
                  number_acc <= W'(sym_q[3:0]);
                  phase      <= iee_pkg::PH_NUMBER;
                end else if (is_minus) begin
                  negate_parity <= ~negate_parity;
                end else begin
                  error_seen <= 1'b1;
                  number_acc <= '0;
                end
              end else if (phase == iee_pkg::PH_NUMBER) begin
                if (is_digit) begin
                  number_acc <= (number_acc << 3) + (number_acc << 1) + W'(sym_q[3:0]);
                end
              end
            end
            iee_pkg::MODE_EVAL: begin
              if (!fresh_start) begin
                if (phase == iee_pkg::PH_OPERAND) begin
                  error_seen <= 1'b1;
                  number_acc <= '0;
                end
                if (phase == iee_pkg::PH_STOPPED) begin
                  fresh_start <= 1'b1;
                end
              end
            end
            iee_pkg::MODE_CLEAR: begin
              sum_acc       <= '0;
              term_acc      <= '0;
              number_acc    <= '0;
              add_is_sub    <= 1'b0;
              mul_pending   <= iee_pkg::PEND_NONE;
              negate_parity <= 1'b0;
              phase         <= iee_pkg::PH_OPERAND;
              error_seen    <= 1'b0;
              fresh_start   <= 1'b1;
            end
            default: begin
            end
          endcase
        end
        iee_pkg::ST_FACTOR: begin
          negate_parity <= 1'b0;
          number_acc    <= '0;
          unique case (mul_pending)
            iee_pkg::PEND_NONE: term_acc <= factor_val;
            iee_pkg::PEND_DIV:  if (factor_val == '0) error_seen <= 1'b1;
            default: begin
            end
          endcase
        end
        iee_pkg::ST_WAIT: begin
          if (md_done) term_acc <= md_result;
        end
        iee_pkg::ST_POST: begin
          if (!is_eval && (is_mul || is_div)) begin
            mul_pending <= is_mul ? iee_pkg::PEND_MUL : iee_pkg::PEND_DIV;
            phase       <= iee_pkg::PH_OPERAND;
          end
        end
        iee_pkg::ST_TERM: begin
          sum_acc     <= add_is_sub ? (sum_acc - term_acc) : (sum_acc + term_acc);
          term_acc    <= '0;
          mul_pending <= iee_pkg::PEND_NONE;
          if (is_eval) begin
            phase       <= iee_pkg::PH_STOPPED;
            fresh_start <= 1'b1;
          end else if (is_plus || is_minus) begin
            add_is_sub <= is_minus;
            phase      <= iee_pkg::PH_OPERAND;
          end else begin
            // unknown key ends the expression
            phase <= iee_pkg::PH_STOPPED;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == iee_pkg::ST_RESULT && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == iee_pkg::ST_RESULT && out_free) begin
      out_data <= is_eval ? {6'b0, 1'b1, error_seen, value_ext} : '0;
    end
  end

endmodule

/* tb/iee_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_result_checker
// Watches the key stream and the result stream of the evaluator. Each key word
// taken in is run through a local model of the parser to get the result word
// it should cause; result words are compared field by field, in order.
// ----------------------------------------------------------------------------
module iee_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // mode[1:0], symbol[9:2], zero pad
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // value[31:0], error[32], done_res[33], zero pad
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    logic [31:0] value;
    logic        error;
    logic        done_res;
  } eval_word_t;

  eval_word_t expected_words[$];

  // parser state
  logic [31:0]      sum_r;
  logic [31:0]      term_r;
  logic [31:0]      number_r;
  logic             sub_next;
  logic             minus_odd;
  logic             err_r;
  logic             fresh_r;
  iee_pkg::pend_t   pend_r;
  iee_pkg::phase_t  phase_r;

  initial fail_count = 0;

  // magnitudes divided unsigned, so the most negative value over -1 wraps
  function automatic logic [31:0] trunc_quotient(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    ma = a[31] ? 32'd0 - a : a;
    mb = b[31] ? 32'd0 - b : b;
    q  = ma / mb;
    return (a[31] ^ b[31]) ? 32'd0 - q : q;
  endfunction

  task automatic clear_expression();
    sum_r     = '0;
    term_r    = '0;
    number_r  = '0;
    sub_next  = 1'b0;
    minus_odd = 1'b0;
    err_r     = 1'b0;
    pend_r    = iee_pkg::PEND_NONE;
    phase_r   = iee_pkg::PH_OPERAND;
  endtask

  task automatic close_factor(input logic [31:0] v);
    logic [31:0] f;
    f = minus_odd ? 32'd0 - v : v;
    case (pend_r)
      iee_pkg::PEND_MUL: term_r = term_r * f;
      iee_pkg::PEND_DIV: begin
        if (f == '0) err_r = 1'b1;
        else term_r = trunc_quotient(term_r, f);
      end
      default: term_r = f;
    endcase
    minus_odd = 1'b0;
    number_r  = '0;
  endtask

  task automatic close_term();
    sum_r  = sub_next ? sum_r - term_r : sum_r + term_r;
    term_r = '0;
    pend_r = iee_pkg::PEND_NONE;
  endtask

  task automatic take_key(input logic [7:0] c);
    logic digit;
    digit = (c >= iee_pkg::CH_0) && (c <= iee_pkg::CH_9);
    if (phase_r == iee_pkg::PH_STOPPED) return;
    if (phase_r == iee_pkg::PH_OPERAND) begin
      if (digit) begin
        number_r = 32'(c - iee_pkg::CH_0);
        phase_r  = iee_pkg::PH_NUMBER;
        return;
      end
      if (c == iee_pkg::CH_MINUS) begin
        minus_odd = ~minus_odd;
        return;
      end
      // operand missing: counts as zero
      err_r    = 1'b1;
      number_r = '0;
    end else if (digit) begin
      number_r = number_r * 32'd10 + 32'(c - iee_pkg::CH_0);
      return;
    end
    close_factor(number_r);
    if (c == iee_pkg::CH_MUL || c == iee_pkg::CH_DIV) begin
      pend_r  = (c == iee_pkg::CH_MUL) ? iee_pkg::PEND_MUL : iee_pkg::PEND_DIV;
      phase_r = iee_pkg::PH_OPERAND;
    end else if (c == iee_pkg::CH_PLUS || c == iee_pkg::CH_MINUS) begin
      close_term();
      sub_next = (c == iee_pkg::CH_MINUS);
      phase_r  = iee_pkg::PH_OPERAND;
    end else begin
      // unknown key ends the expression
      close_term();
      phase_r = iee_pkg::PH_STOPPED;
    end
  endtask

  task automatic predict_word(input logic [1:0] mode, input logic [7:0] sym,
                              output eval_word_t w);
    w = '0;
    case (mode)
      iee_pkg::MODE_SYMBOL: begin
        if (fresh_r) begin
          clear_expression();
          fresh_r = 1'b0;
        end
        take_key(sym);
      end
      iee_pkg::MODE_EVAL: begin
        if (!fresh_r) begin
          if (phase_r == iee_pkg::PH_OPERAND) begin
            err_r = 1'b1;
            close_factor(32'd0);
            close_term();
          end else if (phase_r == iee_pkg::PH_NUMBER) begin
            close_factor(number_r);
            close_term();
          end
          phase_r = iee_pkg::PH_STOPPED;
          fresh_r = 1'b1;
        end
        w.value    = sum_r;
        w.error    = err_r;
        w.done_res = 1'b1;
      end
      iee_pkg::MODE_CLEAR: begin
        clear_expression();
        fresh_r = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    eval_word_t got;
    eval_word_t want;
    if (rst) begin
      clear_expression();
      fresh_r = 1'b1;
      expected_words.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.value    = m_tdata[31:0];
        got.error    = m_tdata[32];
        got.done_res = m_tdata[33];
        if (expected_words.size() == 0) begin
          report_mismatch("result word with none expected", got.value, 32'd0);
        end else begin
          want = expected_words.pop_front();
          if (got.value !== want.value)
            report_mismatch("value", got.value, want.value);
          if (got.error !== want.error)
            report_mismatch("error", 32'(got.error), 32'(want.error));
          if (got.done_res !== want.done_res)
            report_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
        end
      end
      if (s_tvalid && s_tready) begin
        predict_word(s_tdata[1:0], s_tdata[9:2], want);
        expected_words.push_back(want);
      end
    end
    outstanding <= expected_words.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives calculator keys into the expression evaluator: a short directed
// opening, then random expressions with noise, under changing idle patterns
// and receiver hold-offs. The checker beside the block judges every result.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         QUIET_LIMIT = 3000;
  localparam int         HOLD_CYCLES = 300;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        hold_off = 1'b0;

  int fail_count;
  int outstanding;
  int send_idle     = 13;
  int recv_idle     = 68;
  int words_in      = 0;
  int words_counted = 0;
  int quiet_cycles  = 0;

  integer_expression_evaluator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  iee_result_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  // long receiver stalls so the block backs up into its input
  initial begin
    wait (words_in >= 150);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
    wait (words_in >= 700);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** integer_expression_evaluator: FAILED **");
      $finish;
    end
  end

  task automatic send_word(input logic [1:0] mode, input logic [7:0] sym,
                           input bit counted = 1'b1);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, sym, mode};
    do @(posedge clk); while (!s_tready);
    words_in++;
    if (counted) words_counted++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(iee_pkg::MODE_SYMBOL, s[i]);
  endtask

  task automatic send_digits(input int n);
    repeat (n) send_word(iee_pkg::MODE_SYMBOL, iee_pkg::CH_0 + 8'($urandom_range(9)));
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [7:0] stray_key();
    logic [7:0] k;
    do k = 8'($urandom_range(255));
    while ((k >= iee_pkg::CH_0 && k <= iee_pkg::CH_9) || k == iee_pkg::CH_PLUS ||
           k == iee_pkg::CH_MINUS || k == iee_pkg::CH_MUL || k == iee_pkg::CH_DIV);
    return k;
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(3))
      0:       return iee_pkg::CH_PLUS;
      1:       return iee_pkg::CH_MINUS;
      2:       return iee_pkg::CH_MUL;
      default: return iee_pkg::CH_DIV;
    endcase
  endfunction

  task automatic send_operand();
    int pick;
    if ($urandom_range(99) < 20)
      repeat ($urandom_range(1, 3)) send_word(iee_pkg::MODE_SYMBOL, iee_pkg::CH_MINUS);
    pick = $urandom_range(99);
    if (pick < 8) send_word(iee_pkg::MODE_SYMBOL, iee_pkg::CH_0);
    else if (pick < 13) send_text("2147483648");
    else if (pick < 18) send_word(iee_pkg::MODE_SYMBOL, iee_pkg::CH_0 + 8'd1);
    else if (pick < 85) send_digits($urandom_range(1, 3));
    else send_digits($urandom_range(4, 12));
  endtask

  task automatic send_expression();
    int ops;
    int ending;
    logic [7:0] key;
    if ($urandom_range(99) < 3) begin
      // most negative over minus one, and a product that lands on it
      if ($urandom_range(1)) send_text("-2147483648/-1");
      else send_text("65536*32768");
    end else begin
      ops = $urandom_range(4);
      send_operand();
      repeat (ops) begin
        send_word(iee_pkg::MODE_SYMBOL, random_operator());
        if ($urandom_range(99) >= 5) send_operand();
      end
    end
    ending = $urandom_range(99);
    if (ending < 72) begin
      send_word(iee_pkg::MODE_EVAL, 8'($urandom_range(255)));
    end else if (ending < 84) begin
      send_word(iee_pkg::MODE_SYMBOL, stray_key());
      // keys after a stop are ignored
      repeat ($urandom_range(2)) begin
        key = $urandom_range(1) ? random_operator()
                                : iee_pkg::CH_0 + 8'($urandom_range(9));
        send_word(iee_pkg::MODE_SYMBOL, key, 1'b0);
      end
      send_word(iee_pkg::MODE_EVAL, 8'h00);
    end else if (ending < 92) begin
      send_word(iee_pkg::MODE_SYMBOL, random_operator());
      send_word(iee_pkg::MODE_EVAL, 8'h00);
    end else begin
      send_word(iee_pkg::MODE_CLEAR, 8'($urandom_range(255)));
    end
    if ($urandom_range(99) < 10) send_word(iee_pkg::MODE_EVAL, 8'hff);
  endtask

  task automatic run_phase(input int s_pct, input int r_pct, input int count);
    int target;
    send_idle = s_pct;
    recv_idle = r_pct;
    target    = words_counted + count;
    while (words_counted < target) begin
      if ($urandom_range(99) < 8)
        send_word(2'($urandom_range(3)), 8'($urandom_range(255)));
      send_expression();
      if ($urandom_range(99) < 3) wait_for_results();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // evaluate straight after reset, then again
    send_word(iee_pkg::MODE_EVAL, 8'h00);
    send_word(iee_pkg::MODE_EVAL, 8'hff);
    // chained unary minus, then division by zero keeps the term
    send_text("--7/0");
    send_word(iee_pkg::MODE_EVAL, 8'h00);
    // operator where an operand belongs
    send_text("*");
    send_word(iee_pkg::MODE_EVAL, 8'h00);
    // unknown key stops parsing, later keys are ignored
    send_text("3+");
    send_word(iee_pkg::MODE_SYMBOL, 8'hff);
    send_word(iee_pkg::MODE_SYMBOL, iee_pkg::CH_0 + 8'd5, 1'b0);
    send_word(iee_pkg::MODE_EVAL, 8'h00);
    send_word(iee_pkg::MODE_SYMBOL, 8'h00);
    send_word(iee_pkg::MODE_EVAL, 8'h00);
    // clear drops a partial expression
    send_text("4");
    send_word(iee_pkg::MODE_CLEAR, 8'hff);
    send_word(iee_pkg::MODE_EVAL, 8'h00);
    // unused mode does nothing
    send_word(MODE_UNUSED, iee_pkg::CH_0 + 8'd1);
    send_word(iee_pkg::MODE_EVAL, 8'h00);
    // trailing operator before evaluate
    send_text("5-");
    send_word(iee_pkg::MODE_EVAL, 8'h00);
    wait_for_results();

    run_phase(13, 68, 300);
    wait_for_results();
    run_phase(68, 13, 300);
    wait_for_results();
    run_phase(0, 0, 300);

    wait_for_results();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("** integer_expression_evaluator: PASSED **");
    end else begin
      $display("** integer_expression_evaluator: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/iee_pkg.sv
src/iee_muldiv.sv
src/integer_expression_evaluator.sv
tb/iee_result_checker.sv
tb/testbench.sv
